// ===== hdl/lsa_pkg.sv =====
// Shared types and constants for the lease slot allocator.
// Used by lsa_cell and the top level; no dependencies of its own.
`default_nettype none

package lsa_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = ($clog2(MAX_SLOTS + 1) > 5) ? $clog2(MAX_SLOTS + 1) : 5;
  localparam int ID_W      = 64;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ID_W-1:0]  id_t;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Query word handed from cell to cell along the slot row
  typedef struct packed {
    logic valid;
    op_t  op;
    id_t  key;
    idx_t target;
    logic hit;
    idx_t hit_idx;
    logic free;
    idx_t free_idx;
  } token_t;

endpackage

`default_nettype wire

// ===== hdl/lease_slot_allocator.sv =====
// Lease slot allocator top level: request control, counters and the row of slot cells.
// Depends on lsa_pkg and lsa_cell.
//
// Usage:
//   Requests arrive on s_tvalid/s_tready/s_tdata, one result per request leaves on
//   m_tvalid/m_tready/m_tdata. slot_limit is written through cfg_valid/cfg_ready/cfg_data.
//   The user must write it only while the block is idle; the block does not enforce this.
//   cfg_ready is always high. One request is worked on at a time. Each scan of the table
//   is a query that walks the row of MAX_SLOTS cells, one cell a cycle.
//   Health queries and rejected requests go to the result register without a scan.
//   A release makes one clear pass down the row. An acquire that is not rejected makes
//   one scan per id tried, from 1 to limit + 1 ids.
//   The write of a granted id follows down the row behind the result and is always
//   seen by the next request's scan.
//   Reset clears every slot, the count and status, sets generation and the id generator
//   to one and slot_limit to 16. A stalled receiver holds the result in m_tdata; the
//   block still takes and works on one further request, holds that result internally
//   and takes nothing more until the first result has been transferred.
`default_nettype none

module lease_slot_allocator
  import lsa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,   // req_type[1:0], lease_in[65:2], zero fill
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,   // status[2:0], lease_out[66:3], active_count[71:67],
                                       // generation_out[135:72], last_status_out[138:136]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [4:0]   cfg_data
);

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_HEALTH  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_INVALID   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_INTERNAL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACQ_WAIT,
    S_REL_WAIT,
    S_DONE
  } state_t;

  state_t      state;
  logic [4:0]  slot_limit;
  cnt_t        lim;
  cnt_t        live_count;
  id_t         generation;
  id_t         next_id;
  id_t         next_id_next;
  status_t     sticky_status;
  status_t     res_status;
  id_t         res_lease;
  status_t     res_last;
  cnt_t        tries;
  logic        first_try;
  idx_t        free_idx;
  idx_t        free_sel;
  token_t      inject;
  token_t      tok [MAX_SLOTS+1];
  token_t      exit_tok;
  logic [1:0]  req_type;
  id_t         lease_in;

  assign req_type  = s_tdata[1:0];
  assign lease_in  = s_tdata[65:2];
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign lim = (CNT_W'(slot_limit) > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                        : CNT_W'(slot_limit);

  // Generator steps past zero on wrap
  assign next_id_next = (next_id + 64'd1 == 64'd0) ? 64'd1 : next_id + 64'd1;

  assign tok[0]   = inject;
  assign exit_tok = tok[MAX_SLOTS];
  assign free_sel = first_try ? exit_tok.free_idx : free_idx;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    lsa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(g)),
      .lim      (lim),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_limit    <= 5'd16;
      live_count    <= '0;
      generation    <= 64'd1;
      next_id       <= 64'd1;
      sticky_status <= STAT_OK;
      inject        <= '0;
      m_tvalid      <= 1'b0;
      tries         <= '0;
      first_try     <= 1'b0;
    end else begin
      // A query lives one cycle in the inject register; no new one starts in that cycle
      if (inject.valid) begin
        inject <= '0;
      end
      if (cfg_valid && cfg_ready) begin
        slot_limit <= cfg_data;
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_lease <= '0;
            res_last  <= (req_type == REQ_HEALTH) ? sticky_status : STAT_OK;
            case (req_type)
              REQ_ACQUIRE: begin
                if (live_count >= lim) begin
                  res_status    <= STAT_FULL;
                  sticky_status <= STAT_FULL;
                  state         <= S_DONE;
                end else begin
                  inject.valid <= 1'b1;
                  inject.op    <= OP_SCAN;
                  inject.key   <= next_id;
                  tries        <= '0;
                  first_try    <= 1'b1;
                  state        <= S_ACQ_WAIT;
                end
              end
              REQ_RELEASE: begin
                if (lease_in == '0) begin
                  res_status <= STAT_INVALID;
                  state      <= S_DONE;
                end else begin
                  inject.valid <= 1'b1;
                  inject.op    <= OP_CLEAR;
                  inject.key   <= lease_in;
                  state        <= S_REL_WAIT;
                end
              end
              REQ_HEALTH: begin
                res_status    <= STAT_OK;
                sticky_status <= STAT_OK;
                state         <= S_DONE;
              end
              default: begin
                res_status <= STAT_INVALID;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_ACQ_WAIT: begin
          if (exit_tok.valid && exit_tok.op == OP_SCAN) begin
            first_try <= 1'b0;
            if (first_try) begin
              free_idx <= exit_tok.free_idx;
            end
            if (first_try && !exit_tok.free) begin
              res_status    <= STAT_INTERNAL;
              sticky_status <= STAT_INTERNAL;
              state         <= S_DONE;
            end else begin
              next_id <= next_id_next;
              if (exit_tok.key != '0 && !exit_tok.hit) begin
                // Claim the free slot; the write trails down the row
                inject.valid  <= 1'b1;
                inject.op     <= OP_WRITE;
                inject.key    <= exit_tok.key;
                inject.target <= free_sel;
                live_count    <= live_count + 1'b1;
                generation    <= generation + 64'd1;
                res_lease     <= exit_tok.key;
                res_status    <= STAT_OK;
                sticky_status <= STAT_OK;
                state         <= S_DONE;
              end else if (tries == lim) begin
                res_status    <= STAT_INTERNAL;
                sticky_status <= STAT_INTERNAL;
                state         <= S_DONE;
              end else begin
                tries        <= tries + 1'b1;
                inject.valid <= 1'b1;
                inject.op    <= OP_SCAN;
                inject.key   <= next_id_next;
              end
            end
          end
        end

        S_REL_WAIT: begin
          if (exit_tok.valid && exit_tok.op == OP_CLEAR) begin
            if (exit_tok.hit) begin
              if (live_count != '0) begin
                live_count <= live_count - 1'b1;
              end
              generation    <= generation + 64'd1;
              res_status    <= STAT_OK;
              sticky_status <= STAT_OK;
            end else begin
              res_status    <= STAT_NOT_FOUND;
              sticky_status <= STAT_NOT_FOUND;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, res_last, generation, live_count[4:0], res_lease, res_status};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lsa_cell.sv =====
// One lease slot of the allocator row: holds one id and updates the passing query.
// Depends on lsa_pkg.
`default_nettype none

module lsa_cell
  import lsa_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire idx_t   cell_idx,
  input  wire cnt_t   lim,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  id_t    entry;
  token_t tok_next;
  logic   clr;
  logic   wr;
  logic   active;

  assign active = (CNT_W'(cell_idx) < lim);

  always_comb begin
    tok_next = tok_in;
    clr      = 1'b0;
    wr       = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.op) inside
        OP_SCAN, OP_CLEAR: begin
          if (active && entry == tok_in.key && !tok_in.hit) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = cell_idx;
            clr              = (tok_in.op == OP_CLEAR);
          end
          if (active && entry == '0 && !tok_in.free) begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = cell_idx;
          end
        end
        OP_WRITE: begin
          wr = (tok_in.target == cell_idx);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry         <= '0;
      tok_out       <= '0;
    end else begin
      tok_out <= tok_next;
      if (clr) begin
        entry <= '0;
      end else if (wr) begin
        entry <= tok_in.key;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_lease_slot_allocator.sv =====
// Self-checking testbench for lease_slot_allocator: directed and random lease traffic
// scored against a cycle-free predictor of the slot table, counters and status.
// Depends on lsa_pkg and the lease_slot_allocator RTL.
`default_nettype none

module tb_lease_slot_allocator;
  import lsa_pkg::*;

  localparam int RUN_LIMIT    = 5_000_000;
  localparam int RANDOM_ITEMS = 730;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_HEALTH  = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_BAD_ARG = 3'd1,
    RES_FULL    = 3'd2,
    RES_MISSING = 3'd3,
    RES_FAULT   = 3'd4
  } res_code_t;

  // Same layout as m_tdata[138:0], status in the lowest bits
  typedef struct packed {
    logic [2:0] prior_status;
    id_t        generation;
    cnt_t       count;
    id_t        lease;
    logic [2:0] status;
  } lease_report_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;   // req_type[1:0], lease_in[65:2], zero fill
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;   // status[2:0], lease_out[66:3], active_count[71:67],
                           // generation_out[135:72], last_status_out[138:136]
  logic         cfg_valid;
  logic         cfg_ready;
  logic [4:0]   cfg_data;

  // Predicted allocator state
  id_t        slot_ids [MAX_SLOTS];
  cnt_t       held_count;
  id_t        gen_count;
  id_t        id_cursor;
  logic [2:0] sticky_code;
  logic [4:0] slot_limit_reg;

  lease_report_t owed_reports[$];
  int            mismatch_total;
  int            sent_total;
  int            cycle_count;
  bit            steady_flow;

  lease_slot_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Work out the report for one accepted request and advance the predicted state
  task automatic apply_lease_request(input req_kind_t req, input id_t lease);
    int            lim;
    int            i;
    int            j;
    int            tries;
    int            free_slot;
    bit            clash;
    id_t           cand;
    lease_report_t rep;
    lim = (slot_limit_reg > MAX_SLOTS) ? MAX_SLOTS : slot_limit_reg;
    rep = '0;
    rep.status = RES_OK;
    case (req)
      REQ_ACQUIRE: begin
        if (held_count >= lim) begin
          rep.status = RES_FULL;
        end else begin
          free_slot = -1;
          for (i = 0; i < lim && free_slot < 0; i++)
            if (slot_ids[i] == '0) free_slot = i;
          if (free_slot < 0) begin
            rep.status = RES_FAULT;
          end else begin
            // step the generator past zero and past ids live in the searched slots
            for (tries = 0; tries <= lim && rep.lease == '0; tries++) begin
              cand = id_cursor;
              id_cursor = id_cursor + 1'b1;
              if (id_cursor == '0) id_cursor = 64'd1;
              clash = 1'b0;
              for (j = 0; j < lim; j++)
                if (slot_ids[j] == cand) clash = 1'b1;
              if (cand != '0 && !clash) rep.lease = cand;
            end
            if (rep.lease == '0) begin
              rep.status = RES_FAULT;
            end else begin
              slot_ids[free_slot] = rep.lease;
              held_count = held_count + 1'b1;
              gen_count  = gen_count + 1'b1;
            end
          end
        end
        sticky_code = rep.status;
      end
      REQ_RELEASE: begin
        if (lease == '0) begin
          rep.status = RES_BAD_ARG;
        end else begin
          rep.status = RES_MISSING;
          for (i = 0; i < lim && rep.status == RES_MISSING; i++) begin
            if (slot_ids[i] == lease) begin
              slot_ids[i] = '0;
              if (held_count > 0) held_count = held_count - 1'b1;
              gen_count  = gen_count + 1'b1;
              rep.status = RES_OK;
            end
          end
          sticky_code = rep.status;
        end
      end
      REQ_HEALTH: begin
        rep.prior_status = sticky_code;
        sticky_code      = RES_OK;
      end
      default: begin
        rep.status = RES_BAD_ARG;
      end
    endcase
    rep.count      = held_count;
    rep.generation = gen_count;
    owed_reports.push_back(rep);
  endtask

  // Hold the request until transfer; valid stays high for a back-to-back follower
  task automatic send_request(input req_kind_t req, input id_t lease);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, lease, req};
    do @(posedge clk); while (!s_tready);
    apply_lease_request(req, lease);
    sent_total++;
  endtask

  task automatic write_limit(input logic [4:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    // let the trailing slot write leave the row first
    repeat (MAX_SLOTS + 2) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    slot_limit_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver back-pressure: mostly ready, short stalls, the odd long one
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        hold = (steady_flow || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        m_tready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk) begin
    lease_report_t seen;
    lease_report_t want;
    if (m_tvalid && m_tready) begin
      seen = m_tdata[138:0];
      if (owed_reports.size() == 0) begin
        mismatch_total++;
        if (mismatch_total <= 10)
          $display("result with nothing outstanding: status %0d lease %h count %0d gen %h",
                   seen.status, seen.lease, seen.count, seen.generation);
      end else begin
        want = owed_reports.pop_front();
        if (seen.status !== want.status || seen.lease !== want.lease ||
            seen.count !== want.count || seen.generation !== want.generation ||
            seen.prior_status !== want.prior_status) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("mismatch at cycle %0d: status exp %0d got %0d, last exp %0d got %0d",
                     cycle_count, want.status, seen.status, want.prior_status,
                     seen.prior_status);
            $display("  lease exp %h got %h, count exp %0d got %0d, gen exp %h got %h",
                     want.lease, seen.lease, want.count, seen.count,
                     want.generation, seen.generation);
          end
        end
      end
    end
  end

  task automatic test_idle_requests();
    send_request(REQ_HEALTH, '0);
    send_request(REQ_RELEASE, '0);
    send_request(REQ_UNKNOWN, '1);
    send_request(REQ_RELEASE, '1);
    send_request(REQ_UNKNOWN, 64'h5555_5555_5555_5555);
    send_request(REQ_HEALTH, '1);
    send_request(REQ_HEALTH, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_capacity();
    write_limit(5'd2);
    send_request(REQ_ACQUIRE, '1);
    send_request(REQ_ACQUIRE, '0);
    send_request(REQ_ACQUIRE, {$urandom, $urandom});
    send_request(REQ_HEALTH, '0);
    send_request(REQ_RELEASE, slot_ids[0]);
    send_request(REQ_ACQUIRE, '0);
    send_request(REQ_HEALTH, '0);
  endtask

  // Leases in slots past a lowered limit stay counted but cannot be found
  task automatic test_limit_lowered();
    write_limit(5'd16);
    send_request(REQ_ACQUIRE, '0);
    write_limit(5'd1);
    send_request(REQ_RELEASE, slot_ids[2]);
    send_request(REQ_ACQUIRE, '0);
    write_limit(5'd0);
    send_request(REQ_ACQUIRE, '0);
    send_request(REQ_RELEASE, slot_ids[0]);
    write_limit(5'd31);
    send_request(REQ_RELEASE, slot_ids[2]);
    send_request(REQ_HEALTH, '0);
  endtask

  task automatic test_random_traffic();
    int  target;
    int  phase_items;
    int  acquire_pct;
    int  r;
    int  k;
    id_t lease;
    id_t held[$];
    target = sent_total + RANDOM_ITEMS;
    while (sent_total < target) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       write_limit(5'd0);
        1:       write_limit(5'd1);
        2, 3:    write_limit(5'd16);
        4:       write_limit(5'd31);
        5:       write_limit(5'($urandom_range(0, 31)));
        default: write_limit(5'($urandom_range(2, 15)));
      endcase
      steady_flow = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(30, 90);
      acquire_pct = $urandom_range(25, 55);
      repeat (phase_items) begin
        r = $urandom_range(0, 99);
        lease = {$urandom, $urandom};
        if (r < acquire_pct) begin
          send_request(REQ_ACQUIRE, lease);
        end else if (r < acquire_pct + 25) begin
          // release a live lease, wherever it sits in the table
          held.delete();
          for (k = 0; k < MAX_SLOTS; k++)
            if (slot_ids[k] != '0) held.push_back(slot_ids[k]);
          if (held.size() != 0) lease = held[$urandom_range(0, held.size() - 1)];
          send_request(REQ_RELEASE, lease);
        end else if (r < acquire_pct + 30) begin
          send_request(REQ_RELEASE, lease);
        end else if (r < acquire_pct + 32) begin
          send_request(REQ_RELEASE, '0);
        end else if (r < acquire_pct + 37) begin
          send_request(REQ_UNKNOWN, lease);
        end else begin
          send_request(REQ_HEALTH, lease);
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    steady_flow    = 1'b0;
    mismatch_total = 0;
    sent_total     = 0;
    for (int i = 0; i < MAX_SLOTS; i++) slot_ids[i] = '0;
    held_count     = '0;
    gen_count      = 64'd1;
    id_cursor      = 64'd1;
    sticky_code    = RES_OK;
    slot_limit_reg = 5'd16;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_capacity();
    test_limit_lowered();
    test_random_traffic();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (4 * MAX_SLOTS) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/lsa_pkg.sv
hdl/lsa_cell.sv
hdl/lease_slot_allocator.sv
tb/sv/tb_lease_slot_allocator.sv
